FILE: rtl/ptcomp_pkg.sv
// shared types and constants for the pressure/temperature compensation unit
// no dependencies; imported by pressure_temperature_compensation_unit
`default_nettype none

package ptcomp_pkg;

  localparam int COEFF_W     = 16;
  localparam int RAW_W       = 24;
  localparam int TEMP_W      = 19;
  localparam int PRES_W      = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int NUM_STAGES  = 10;

  // calibration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SENS        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } ptcomp_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_decimbar;
  } ptcomp_out_t;

endpackage

`default_nettype wire

FILE: rtl/pressure_temperature_compensation_unit.sv
// pressure/temperature compensation unit: ten-stage pipeline, first and second order terms
// depends on ptcomp_pkg
`default_nettype none

// Usage
//   sample channel: sample_valid / sample_stall carry one word holding the raw
//   pressure and raw temperature conversions. A word is taken at a clock edge
//   with sample_valid high and sample_stall low.
//   result channel: result_valid / result_stall carry the compensated
//   temperature (0.01 degC) and pressure (0.1 mbar), both saturated.
//   cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data writes one of
//   six calibration words; cfg_ready is always high, indexes above five are
//   dropped. Write calibration only while no word is in flight.
//   One word per cycle is sustained while result_stall is low; the ten
//   register stages each hold one word in flight.
//   A stalled result holds its word; stages behind it keep filling bubbles and
//   sample_stall rises only once every stage is occupied.
//   Synchronous reset (rst) empties the pipeline and clears the calibration
//   words to zero.
module pressure_temperature_compensation_unit
  import ptcomp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  ptcomp_in_t             sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ptcomp_out_t            result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]     cfg_data
);

  logic [COEFF_W-1:0] sens_coeff;
  logic [COEFF_W-1:0] offset_coeff;
  logic [COEFF_W-1:0] sens_temp_coeff;
  logic [COEFF_W-1:0] offset_temp_coeff;
  logic [COEFF_W-1:0] ref_temp_coeff;
  logic [COEFF_W-1:0] temp_slope_coeff;

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_en;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff        <= '0;
      offset_coeff      <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      ref_temp_coeff    <= '0;
      temp_slope_coeff  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENS:        sens_coeff        <= cfg_data;
        REG_OFFSET:      offset_coeff      <= cfg_data;
        REG_SENS_TEMP:   sens_temp_coeff   <= cfg_data;
        REG_OFFSET_TEMP: offset_temp_coeff <= cfg_data;
        REG_REF_TEMP:    ref_temp_coeff    <= cfg_data;
        REG_TEMP_SLOPE:  temp_slope_coeff  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // a stage moves on when it is empty or the one after it moves
  always_comb begin
    stage_en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign sample_stall = !stage_en[0];
  assign result_valid = stage_valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= sample_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: dT
  logic signed [24:0] dt1;
  logic [RAW_W-1:0]   d1_1;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dt1  <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, ref_temp_coeff, 8'd0});
      d1_1 <= sample.raw_pressure;
    end
  end

  // ---------------------------------------------------------------- stage 2: products of dT
  logic signed [41:0] slope_prod_w, offt_prod_w, senst_prod_w;
  logic signed [49:0] dt_sq_w;
  logic signed [41:0] slope_prod2, offt_prod2, senst_prod2;
  logic [47:0]        dt_sq2;
  logic [RAW_W-1:0]   d1_2;

  assign slope_prod_w = dt1 * $signed({1'b0, temp_slope_coeff});
  assign offt_prod_w  = dt1 * $signed({1'b0, offset_temp_coeff});
  assign senst_prod_w = dt1 * $signed({1'b0, sens_temp_coeff});
  assign dt_sq_w      = dt1 * dt1;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      slope_prod2 <= slope_prod_w;
      offt_prod2  <= offt_prod_w;
      senst_prod2 <= senst_prod_w;
      dt_sq2      <= dt_sq_w[47:0];
      d1_2        <= d1_1;
    end
  end

  // ---------------------------------------------------------------- stage 3: T1 deviation, OFF, SENS
  // divisions round toward zero: bias negative values before the shift
  logic signed [41:0] slope_shr, offt_shr, senst_shr;
  logic [49:0]        dt_sq_x3;
  logic signed [17:0] dev3;
  logic signed [35:0] off3;
  logic signed [34:0] sens3;
  logic [16:0]        ti_low3;
  logic [11:0]        ti_high3;
  logic [RAW_W-1:0]   d1_3;

  assign slope_shr = (slope_prod2 + (slope_prod2[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
  assign offt_shr  = (offt_prod2 + (offt_prod2[41] ? 42'sd127 : 42'sd0)) >>> 7;
  assign senst_shr = (senst_prod2 + (senst_prod2[41] ? 42'sd255 : 42'sd0)) >>> 8;
  assign dt_sq_x3  = {2'b00, dt_sq2} + {1'b0, dt_sq2, 1'b0};

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      dev3     <= slope_shr[17:0];
      off3     <= $signed({4'd0, offset_coeff, 16'd0}) + offt_shr[35:0];
      sens3    <= $signed({4'd0, sens_coeff, 15'd0}) + senst_shr[34:0];
      ti_low3  <= dt_sq_x3[49:33];
      ti_high3 <= dt_sq2[47:36];
      d1_3     <= d1_2;
    end
  end

  // ---------------------------------------------------------------- stage 4: squares, temperature
  logic signed [18:0] t1_w, w_w;
  logic signed [35:0] dev_sq_w;
  logic signed [37:0] w_sq_w;
  logic [16:0]        ti_sel;
  logic signed [19:0] temp_w;
  logic signed [TEMP_W-1:0] temp_sat;
  logic               low_w, vlow_w;

  logic [34:0]        dev_sq4, w_sq4;
  logic               low4, vlow4;
  logic signed [35:0] off4;
  logic signed [34:0] sens4;
  logic signed [TEMP_W-1:0] temp4;
  logic [RAW_W-1:0]   d1_4;

  assign t1_w     = {dev3[17], dev3} + 19'sd2000;
  assign w_w      = {dev3[17], dev3} + 19'sd3500;
  assign dev_sq_w = dev3 * dev3;
  assign w_sq_w   = w_w * w_w;
  assign low_w    = dev3[17];
  assign vlow_w   = dev3 <= -18'sd3600;
  assign ti_sel   = low_w ? ti_low3 : {5'd0, ti_high3};
  assign temp_w   = {t1_w[18], t1_w} - $signed({3'd0, ti_sel});

  always_comb begin
    if (temp_w > 20'sd262143) begin
      temp_sat = 19'sh3FFFF;
    end else if (temp_w < -20'sd262144) begin
      temp_sat = 19'sh40000;
    end else begin
      temp_sat = temp_w[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      dev_sq4 <= dev_sq_w[34:0];
      w_sq4   <= w_sq_w[34:0];
      low4    <= low_w;
      vlow4   <= vlow_w;
      off4    <= off3;
      sens4   <= sens3;
      temp4   <= temp_sat;
      d1_4    <= d1_3;
    end
  end

  // ---------------------------------------------------------------- stage 5: second order terms
  logic [39:0] dev_sq_3x, dev_sq_5x, w_sq_7x, w_sq_4x;
  logic [39:0] offi_w, sensi_w;
  logic signed [39:0] sdiff5;
  logic signed [40:0] odiff5;
  logic signed [TEMP_W-1:0] temp5;
  logic [RAW_W-1:0]   d1_5;

  assign dev_sq_3x = {5'd0, dev_sq4} + {4'd0, dev_sq4, 1'b0};
  assign dev_sq_5x = {5'd0, dev_sq4} + {3'd0, dev_sq4, 2'b00};
  assign w_sq_7x   = {2'd0, w_sq4, 3'b000} - {5'd0, w_sq4};
  assign w_sq_4x   = {3'd0, w_sq4, 2'b00};

  always_comb begin
    if (low4) begin
      offi_w  = {1'b0, dev_sq_3x[39:1]} + (vlow4 ? w_sq_7x : 40'd0);
      sensi_w = {3'd0, dev_sq_5x[39:3]} + (vlow4 ? w_sq_4x : 40'd0);
    end else begin
      offi_w  = {9'd0, dev_sq4[34:4]};
      sensi_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      sdiff5 <= {{5{sens4[34]}}, sens4} - $signed(sensi_w);
      odiff5 <= {{5{off4[35]}}, off4} - $signed({1'b0, offi_w});
      temp5  <= temp4;
      d1_5   <= d1_4;
    end
  end

  // ---------------------------------------------------------------- stage 6: D1 partial products
  logic [43:0]        lo_w;
  logic signed [44:0] hi_w;
  logic [43:0]        lo6;
  logic signed [44:0] hi6;
  logic signed [40:0] odiff6;
  logic signed [TEMP_W-1:0] temp6;

  assign lo_w = d1_5 * sdiff5[19:0];
  assign hi_w = $signed({1'b0, d1_5}) * $signed(sdiff5[39:20]);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      lo6    <= lo_w;
      hi6    <= hi_w;
      odiff6 <= odiff5;
      temp6  <= temp5;
    end
  end

  // ---------------------------------------------------------------- stage 7: full product
  logic signed [63:0] prod7;
  logic signed [40:0] odiff7;
  logic signed [TEMP_W-1:0] temp7;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      prod7  <= $signed({hi6[43:0], 20'd0}) + $signed({20'd0, lo6});
      odiff7 <= odiff6;
      temp7  <= temp6;
    end
  end

  // ---------------------------------------------------------------- stage 8: product / 2^21
  logic signed [63:0] prod_shr;
  logic signed [42:0] scaled8;
  logic signed [40:0] odiff8;
  logic signed [TEMP_W-1:0] temp8;

  assign prod_shr = (prod7 + (prod7[63] ? 64'sd2097151 : 64'sd0)) >>> 21;

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      scaled8 <= prod_shr[42:0];
      odiff8  <= odiff7;
      temp8   <= temp7;
    end
  end

  // ---------------------------------------------------------------- stage 9: minus offset
  logic signed [43:0] pdiff9;
  logic signed [TEMP_W-1:0] temp9;

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      pdiff9 <= {scaled8[42], scaled8} - {{3{odiff8[40]}}, odiff8};
      temp9  <= temp8;
    end
  end

  // ---------------------------------------------------------------- stage 10: / 2^13, saturate
  logic signed [43:0] pres_shr;
  logic signed [PRES_W-1:0] pres_sat;
  logic signed [TEMP_W-1:0] res_temp;
  logic signed [PRES_W-1:0] res_pres;

  assign pres_shr = (pdiff9 + (pdiff9[43] ? 44'sd8191 : 44'sd0)) >>> 13;

  always_comb begin
    if (pres_shr > 44'sd8388607) begin
      pres_sat = 24'sh7FFFFF;
    end else if (pres_shr < -44'sd8388608) begin
      pres_sat = 24'sh800000;
    end else begin
      pres_sat = pres_shr[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      res_temp <= temp9;
      res_pres <= pres_sat;
    end
  end

  assign result.temperature_centi = res_temp;
  assign result.pressure_decimbar = res_pres;

  // ---------------------------------------------------------------- checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (&stage_valid))
    else $error("input stalled while the pipeline has a free stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> stage_valid[0])
    else $error("accepted word did not enter the first stage");

  a_very_low_is_low: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[3] && vlow4) |-> low4)
    else $error("very low temperature branch without low branch");

  a_held_result_stays: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[NUM_STAGES-1] && result_stall) |=> stage_valid[NUM_STAGES-1])
    else $error("stalled result word dropped");

endmodule

`default_nettype wire
